### design/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property sampled on the block clock, switched off while reset is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Overlapping implication built on the macro above.
`define ASSERT_IMPL(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |-> (cons), msg)

// Next-cycle implication built on the first macro.
`define ASSERT_NEXT(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

### design/dtoi_pkg.sv
// Types and constants of the decimal text to integer converter.
`timescale 1ns / 1ps
`default_nettype none

package dtoi_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned NumW  = 32;
  localparam int unsigned DigW  = 4;
  // magnitude*10 + 9 stays below 2^36 for any 32-bit magnitude
  localparam int unsigned WideW = NumW + 4;

  localparam logic [CharW-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CharW-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CharW-1:0] CHAR_MINUS = 8'h2D;

  localparam logic [WideW-1:0] U16_MAX       = 36'd65535;
  // largest positive 32-bit value split as /10 and %10; the negative limit adds one
  // to the last digit
  localparam logic [NumW-1:0]  S32_LIM_DIV10 = 32'd214748364;
  localparam logic [DigW-1:0]  S32_LIM_MOD10 = 4'd7;

  typedef struct packed {
    logic            at_first;
    logic            is_neg;
    logic [NumW-1:0] mag;
    logic            seen_digit;
    logic            failed;
  } dtoi_state_t;

  localparam dtoi_state_t STATE_CLEAR = '{
    at_first:   1'b1,
    is_neg:     1'b0,
    mag:        '0,
    seen_digit: 1'b0,
    failed:     1'b0
  };

  typedef struct packed {
    logic            ok;
    logic [NumW-1:0] number;
  } dtoi_result_t;

endpackage

`default_nettype wire

### design/decimal_text_to_integer_core.sv
// Top level of the decimal text to integer converter.
`timescale 1ns / 1ps
`default_nettype none
// Usage
//   Slave stream: one ASCII character per item in s_axis_tdata[7:0]; an item with
//   s_axis_tlast high closes the string and its character is ignored.
//   Master stream: one result per terminator; m_axis_tuser[0] is ok, m_axis_tdata
//   the two's complement number (zero when ok is low). Characters give no result.
//   Config channel: cfg_data_i[0] selects signed 32-bit (1) or unsigned 16-bit (0)
//   parsing; always ready; write it only while no string item is in flight.
// Timing
//   An item is held in an input register, then the parse logic updates the
//   state and, on a terminator, loads the result register, which drives
//   m_axis_tvalid.
//   Throughput is one item per clock while no terminator waits on a full result
//   register; the loop is the x10-add-compare on the 32-bit magnitude.
// Reset and stall
//   Reset clears the parse state, empties both registers, and sets signed mode.
//   While a result waits on m_axis_tready, characters still flow; only a
//   further terminator waits in the input register, and s_axis_tready drops
//   once that register cannot move on.

module decimal_text_to_integer_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [0:0]  cfg_data_i,      // [0] signed_mode
  // slave stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,    // [7:0] character
  input  wire logic        s_axis_tlast,    // is_end
  // master stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,    // [31:0] number
  output logic [0:0]       m_axis_tuser     // [0] ok
);
  import dtoi_pkg::*;

  logic                 mode_q;
  logic                 in_vld_q;
  logic [CharW-1:0]     in_char_q;
  logic                 in_end_q;
  dtoi_state_t          st_q, st_d, st_step;
  dtoi_result_t         res_q, res_step;
  logic                 out_vld_q;

  logic                 out_free;
  logic                 proc;
  logic                 take_in;

  assign cfg_ready_o = 1'b1;

  // a terminator needs room in the result register, a character never does
  assign out_free      = !out_vld_q || m_axis_tready;
  assign proc          = in_vld_q && (!in_end_q || out_free);
  assign s_axis_tready = !in_vld_q || proc;
  assign take_in       = s_axis_tvalid && s_axis_tready;

  dtoi_step u_step (
    .state_i       (st_q),
    .char_i        (in_char_q),
    .signed_mode_i (mode_q),
    .state_o       (st_step),
    .result_o      (res_step)
  );

  always_comb begin
    st_d = st_q;
    if (proc) begin
      st_d = in_end_q ? STATE_CLEAR : st_step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b1;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= STATE_CLEAR;
    end else begin
      st_q <= st_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= cfg_data_i[0];
      end
      if (take_in) begin
        in_vld_q <= 1'b1;
      end else if (proc) begin
        in_vld_q <= 1'b0;
      end
      if (proc && in_end_q) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_char_q <= s_axis_tdata;
      in_end_q  <= s_axis_tlast;
    end
    if (proc && in_end_q) begin
      res_q <= res_step;
    end
  end

  assign m_axis_tvalid   = out_vld_q;
  assign m_axis_tdata    = res_q.number;
  assign m_axis_tuser[0] = res_q.ok;

endmodule

`default_nettype wire

### design/dtoi_step.sv
// Single-character parse update and terminator result of the converter.
`timescale 1ns / 1ps
`default_nettype none

module dtoi_step (
  input  wire dtoi_pkg::dtoi_state_t  state_i,
  input  wire logic [7:0]             char_i,
  input  wire logic                   signed_mode_i,
  output dtoi_pkg::dtoi_state_t       state_o,
  output dtoi_pkg::dtoi_result_t      result_o
);
  import dtoi_pkg::*;

  logic              is_sign;
  logic              is_digit;
  logic [CharW-1:0]  char_off;
  logic [DigW-1:0]   digit;
  logic [WideW-1:0]  mag_w;
  logic [WideW-1:0]  next_w;
  logic [DigW-1:0]   last_lim;
  logic              ovf_s;
  logic              ovf_u;
  logic              ovf;

  assign is_sign  = signed_mode_i && state_i.at_first &&
                    (char_i == CHAR_PLUS || char_i == CHAR_MINUS);
  assign is_digit = (char_i >= CHAR_ZERO) && (char_i <= CHAR_NINE);
  assign char_off = char_i - CHAR_ZERO;
  assign digit    = char_off[DigW-1:0];

  // x10 as two shifts and an add
  assign mag_w  = {{(WideW-NumW){1'b0}}, state_i.mag};
  assign next_w = (mag_w << 3) + (mag_w << 1) + {{(WideW-DigW){1'b0}}, digit};

  assign last_lim = S32_LIM_MOD10 + {{(DigW-1){1'b0}}, state_i.is_neg};
  assign ovf_s    = (state_i.mag > S32_LIM_DIV10) ||
                    (state_i.mag == S32_LIM_DIV10 && digit > last_lim);
  assign ovf_u    = next_w > U16_MAX;
  assign ovf      = signed_mode_i ? ovf_s : ovf_u;

  always_comb begin
    state_o          = state_i;
    state_o.at_first = 1'b0;
    if (!state_i.failed) begin
      if (is_sign) begin
        state_o.is_neg = (char_i == CHAR_MINUS);
      end else if (!is_digit || ovf) begin
        state_o.failed = 1'b1;
      end else begin
        state_o.mag        = next_w[NumW-1:0];
        state_o.seen_digit = 1'b1;
      end
    end
  end

  always_comb begin
    result_o.ok     = !state_i.failed && state_i.seen_digit;
    result_o.number = '0;
    if (result_o.ok) begin
      result_o.number = state_i.is_neg ? (NumW'(0) - state_i.mag) : state_i.mag;
    end
  end

endmodule

`default_nettype wire

### design/dtoi_checker.sv
// Port-level checks of the converter, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dtoi_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        s_axis_tlast,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic [0:0]  m_axis_tuser
);

  // a failed parse reports zero
  `ASSERT_IMPL(a_fail_zero, m_axis_tvalid && !m_axis_tuser[0],
               m_axis_tdata == 32'd0, "failed result with non-zero number")

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
               m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
               "stalled result changed")

  // a fresh result follows a taken terminator
  `ASSERT_IMPL(a_res_src, $rose(m_axis_tvalid),
               $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2),
               "result without terminator")

  // with the result register empty nothing can hold the input back
  `ASSERT_IMPL(a_in_ready, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")

endmodule

bind decimal_text_to_integer_core dtoi_checker u_dtoi_checker (.*);

`default_nettype wire

### tb/tb_decimal_text_to_integer_core.sv
// Self-checking testbench of the decimal text to integer converter.
`timescale 1ns / 1ps

module tb_decimal_text_to_integer_core;
  import dtoi_pkg::*;

  typedef logic [7:0] text_t [$];

  localparam logic MODE_U16 = 1'b0;
  localparam logic MODE_S32 = 1'b1;

  localparam longint unsigned S32_MAX = 64'd2147483647;
  localparam longint unsigned U16_TOP = 64'd65535;
  localparam longint unsigned RADIX   = 64'd10;

  // drain wait after the last result, with margin over the input and result registers
  localparam int unsigned PIPE_DRAIN = 4;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RANDOM_ITEMS = 280;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic [0:0]  cfg_data_i    = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tready = 1'b0;
  logic        cfg_ready_o;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [31:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  // predictor copy of the register and the parse state
  logic        p_mode   = MODE_S32;
  logic        p_first  = 1'b1;
  logic        p_neg    = 1'b0;
  logic [31:0] p_mag    = '0;
  logic        p_seen   = 1'b0;
  logic        p_failed = 1'b0;

  dtoi_result_t parsed_q[$];
  int unsigned  items_sent = 0;
  int unsigned  mismatches = 0;
  bit           calm       = 1'b0;
  bit           hold_req   = 1'b0;

  decimal_text_to_integer_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [7:0] character
    .s_axis_tlast (s_axis_tlast),   // is_end
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // [31:0] number
    .m_axis_tuser (m_axis_tuser)    // [0] ok
  );

  always #10 clk_i = ~clk_i;

  // Predictor: one accepted item in, at most one expected result out.
  function automatic void parse_item(input logic [7:0] ch, input logic last);
    dtoi_result_t res;
    logic first;
    longint unsigned dig, lim, nxt;
    if (last) begin
      res.ok     = !p_failed && p_seen;
      res.number = res.ok ? (p_neg ? -p_mag : p_mag) : '0;
      parsed_q.push_back(res);
      p_first  = 1'b1;
      p_neg    = 1'b0;
      p_mag    = '0;
      p_seen   = 1'b0;
      p_failed = 1'b0;
      return;
    end
    first   = p_first;
    p_first = 1'b0;
    if (p_failed) return;
    if (p_mode == MODE_S32 && first && (ch == CHAR_PLUS || ch == CHAR_MINUS)) begin
      p_neg = (ch == CHAR_MINUS);
      return;
    end
    if (ch < CHAR_ZERO || ch > CHAR_NINE) begin
      p_failed = 1'b1;
      return;
    end
    dig = longint'(ch - CHAR_ZERO);
    if (p_mode == MODE_S32) begin
      // the negative side reaches one further
      lim = S32_MAX + longint'(p_neg);
      if (p_mag > lim / RADIX || (p_mag == lim / RADIX && dig > lim % RADIX)) begin
        p_failed = 1'b1;
        return;
      end
      nxt = longint'(p_mag) * RADIX + dig;
    end else begin
      nxt = longint'(p_mag) * RADIX + dig;
      if (nxt > U16_TOP) begin
        p_failed = 1'b1;
        return;
      end
    end
    p_mag  = nxt[31:0];
    p_seen = 1'b1;
  endfunction

  function automatic text_t digits_of(input longint unsigned v, input int unsigned pad);
    text_t t;
    do begin
      t.push_front(8'(longint'(CHAR_ZERO) + v % RADIX));
      v = v / RADIX;
    end while (v != 0);
    repeat (pad) t.push_front(CHAR_ZERO);
    return t;
  endfunction

  // Sends one item; valid stays high after acceptance so back-to-back items need no dip.
  task automatic push_item(input logic [7:0] ch, input logic last);
    while (!calm && $urandom_range(99) < 35) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    parse_item(ch, last);
    items_sent++;
  endtask

  task automatic send_text(input text_t txt, input logic [7:0] term_ch);
    foreach (txt[i]) push_item(txt[i], 1'b0);
    push_item(term_ch, 1'b1);
  endtask

  task automatic send_str(input string s, input logic [7:0] term_ch);
    text_t txt;
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    send_text(txt, term_ch);
  endtask

  // Idle point: every result in, then let trailing characters leave the pipe.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (parsed_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_DRAIN) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic mode);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    p_mode = mode;
  endtask

  // Mostly well-formed numbers, some near the limits, some corrupted, some pure noise.
  task automatic send_random_string();
    text_t txt;
    int unsigned pick, pos;
    longint unsigned mag, top;
    pick = $urandom_range(99);
    if (pick < 10) begin
      repeat ($urandom_range(5)) txt.push_back(8'($urandom_range(255)));
    end else begin
      top = (p_mode == MODE_S32) ? S32_MAX : U16_TOP;
      case ($urandom_range(4))
        0: mag = top - 2 + $urandom_range(3);
        1: mag = $urandom_range(99);
        2: mag = (p_mode == MODE_S32) ? longint'($urandom) * 3
                                      : longint'($urandom_range(200000));
        default: mag = (p_mode == MODE_S32) ? longint'($urandom_range(32'h7FFF_FFFF))
                                            : longint'($urandom_range(65535));
      endcase
      txt = digits_of(mag, ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0);
      if (p_mode == MODE_S32 || $urandom_range(19) == 0) begin
        case ($urandom_range(2))
          1: txt.push_front(CHAR_MINUS);
          2: txt.push_front(CHAR_PLUS);
          default: ;
        endcase
      end
      if (pick < 30) begin
        pos = $urandom_range(txt.size());
        if ($urandom_range(1) == 1) txt.insert(pos, 8'($urandom_range(255)));
        else if (pos < txt.size()) txt[pos] = 8'($urandom_range(255));
      end
    end
    send_text(txt, 8'($urandom_range(255)));
  endtask

  // Signed mode straight out of reset: empty, sign only, late sign, bad and NUL chars.
  task automatic test_signed_corners();
    send_str("", 8'hFF);
    send_str("-", 8'h00);
    send_str("+5", 8'h35);
    send_str("5-", 8'hFF);
    send_str("a1", 8'h00);
    push_item(8'h00, 1'b0);
    push_item(8'h31, 1'b1);
    settle();
  endtask

  task automatic test_unsigned_sign();
    write_mode(MODE_U16);
    send_str("+1", 8'h00);
    settle();
  endtask

  // Mode flipped between characters of one string: sign and digits gathered are kept.
  task automatic test_mode_mid_string();
    write_mode(MODE_S32);
    push_item(CHAR_MINUS, 1'b0);
    push_item(8'h31, 1'b0);
    settle();
    write_mode(MODE_U16);
    push_item(8'h32, 1'b0);
    push_item(8'hFF, 1'b1);
    settle();
  endtask

  task automatic test_random_phases();
    int unsigned goal;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      settle();
      write_mode(logic'($urandom_range(1)));
      repeat (8) send_random_string();
    end
    settle();
  endtask

  task automatic test_calm_stream();
    calm = 1'b1;
    repeat (12) send_random_string();
    calm = 1'b0;
    settle();
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (25) send_random_string();
    settle();
  endtask

  // Receiver: random stalls, or one long hold-off when asked.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 35);
      end
    end
  end

  // Result check against the oldest expectation.
  always @(posedge clk_i) begin : result_check
    dtoi_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (parsed_q.size() == 0) begin
        $error("unexpected result: ok=%0d number=%0d", m_axis_tuser[0],
               $signed(m_axis_tdata));
        mismatches++;
      end else begin
        want = parsed_q.pop_front();
        if (m_axis_tuser[0] !== want.ok) begin
          $error("ok: expected %0d actual %0d", want.ok, m_axis_tuser[0]);
          mismatches++;
        end
        if (m_axis_tdata !== want.number) begin
          $error("number: expected %0d actual %0d", $signed(want.number),
                 $signed(m_axis_tdata));
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_signed_corners();
    test_unsigned_sign();
    test_mode_mid_string();
    test_random_phases();
    test_calm_stream();
    test_backpressure();
    settle();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && parsed_q.size() == 0) begin
      $display("tb_decimal_text_to_integer_core OK");
    end else begin
      $display("tb_decimal_text_to_integer_core NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_decimal_text_to_integer_core NOT OK");
    $finish;
  end

endmodule
